// ===== design/ordered_list_insert_erase_assert.svh =====
// Assertion macros used by the checker file of the ordered list block.
// Every macro samples on the rising edge of i_clk and is disabled while
// i_rst_n is low.
`ifndef ORDERED_LIST_INSERT_ERASE_ASSERT_SVH
`define ORDERED_LIST_INSERT_ERASE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OLIE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("ordered list check failed");

// Consequent must hold in the cycle after the antecedent.
`define OLIE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("ordered list check failed");

`endif

// ===== design/olie_pkg.sv =====
`default_nettype none

package olie_pkg;

    // List capacity; IDX_W and CNT_W follow from it.
    localparam int CAPACITY = 16;

    localparam int DATA_W = 32;
    localparam int KIND_W = 2;
    localparam int POS_W  = 5;
    localparam int STAT_W = 2;
    localparam int FIDX_W = 4;
    localparam int ECNT_W = 5;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Common width for comparing positions against the count.
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    // Working widths for the result fields before truncation.
    localparam int FW = (IDX_W > FIDX_W) ? IDX_W : FIDX_W;
    localparam int CW = (CNT_W > ECNT_W) ? CNT_W : ECNT_W;

    localparam logic [KIND_W-1:0] OP_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] OP_ERASE  = 2'd1;
    localparam logic [KIND_W-1:0] OP_FIND   = 2'd2;
    localparam logic [KIND_W-1:0] OP_MODIFY = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap;   // capture the incoming operation
        logic exec;  // perform the held operation and load the result
    } t_olie_cmd;

endpackage

`default_nettype wire

// ===== design/olie_ctrl.sv =====
`default_nettype none

module olie_ctrl
    import olie_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_olie_cmd      o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic out_free;

    // The result register can take a new beat when empty or being drained.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd.cap  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec = (r_state == S_EXEC) && out_free;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== design/olie_dpath.sv =====
`default_nettype none

module olie_dpath
    import olie_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_olie_cmd                i_cmd,
    input  wire logic [KIND_W-1:0]        i_kind,
    input  wire logic [POS_W-1:0]         i_position,
    input  wire logic signed [DATA_W-1:0] i_value,
    output logic [STAT_W-1:0]             o_status,
    output logic [FIDX_W-1:0]             o_found_index,
    output logic [ECNT_W-1:0]             o_entry_count
);

    logic [KIND_W-1:0]        r_kind;
    logic [POS_W-1:0]         r_pos;
    logic signed [DATA_W-1:0] r_value;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [STAT_W-1:0]        r_status;
    logic [STAT_W-1:0]        n_status;
    logic [FW-1:0]            r_found;
    logic [FW-1:0]            n_found;
    logic signed [DATA_W-1:0] r_entries [CAPACITY];

    logic [CAPACITY-1:0] match;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    cnt_ext;
    logic [CW-1:0]       cnt_out;
    logic                ins_ok;
    logic                ers_ok;
    logic                mod_ok;

    assign pos_ext = CMP_W'(r_pos);
    assign cnt_ext = CMP_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_kind  <= i_kind;
            r_pos   <= i_position;
            r_value <= i_value;
        end
    end

    // One cell per entry: each compares against the search word and takes its
    // new value from itself, a neighbor or the incoming word.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign match[g] = (CMP_W'(g) < cnt_ext) && (r_entries[g] == r_value);

        always_ff @(posedge i_clk) begin
            if (i_cmd.exec) begin
                if (ins_ok && (CMP_W'(g) == pos_ext)) begin
                    r_entries[g] <= r_value;
                end else if (mod_ok && (CMP_W'(g) == pos_ext)) begin
                    r_entries[g] <= r_value;
                end else if (ins_ok && (CMP_W'(g) > pos_ext)) begin
                    r_entries[g] <= r_entries[(g > 0) ? g - 1 : 0];
                end else if (ers_ok && (CMP_W'(g) >= pos_ext) && (g < CAPACITY - 1)) begin
                    r_entries[g] <= r_entries[(g < CAPACITY - 1) ? g + 1 : g];
                end
            end
        end
    end

    always_comb begin
        n_status = ST_OK;
        n_found  = '0;
        n_count  = r_count;
        ins_ok   = 1'b0;
        ers_ok   = 1'b0;
        mod_ok   = 1'b0;
        unique case (r_kind)
            OP_INSERT: begin
                priority if (pos_ext > cnt_ext) begin
                    n_status = ST_BADPOS;
                end else if (cnt_ext == CMP_W'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else begin
                    ins_ok  = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_ERASE: begin
                if (pos_ext >= cnt_ext) begin
                    n_status = ST_BADPOS;
                end else begin
                    ers_ok  = 1'b1;
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_FIND: begin
                n_status = ST_NOTFOUND;
                for (int k = CAPACITY - 1; k >= 0; k--) begin
                    if (match[k]) begin
                        n_status = ST_OK;
                        n_found  = FW'(k);
                    end
                end
            end
            OP_MODIFY: begin
                if (pos_ext >= cnt_ext) begin
                    n_status = ST_BADPOS;
                end else begin
                    mod_ok = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_found  <= n_found;
        end
    end

    // The count only moves when a new result is loaded, so it serves directly
    // as the entry count of the result on display.
    assign cnt_out       = CW'(r_count);
    assign o_status      = r_status;
    assign o_found_index = r_found[FIDX_W-1:0];
    assign o_entry_count = cnt_out[ECNT_W-1:0];

endmodule

`default_nettype wire

// ===== design/ordered_list_insert_erase.sv =====
`default_nettype none

// Ordered list of up to 16 signed 32-bit words. Each input beat carries one
// operation (insert, erase, find or modify) and produces exactly one result
// beat with a status, the index of the first match for a find, and the number
// of entries held afterwards. Bad positions, inserts into a full list and
// failed finds are reported in the status and leave the list untouched. The
// block takes no new beat until the last one has executed. It captures the beat;
// on execute every entry cell shifts, overwrites or compares in parallel
// and the result register is loaded. The result is valid the cycle after the
// execute cycle, and a new beat may be accepted while it still waits to be
// taken; a result held back by i_out_stall delays only the next execute cycle.
// The list is empty after reset and needs no clearing pass.
module ordered_list_insert_erase
    import olie_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [KIND_W-1:0]        i_kind,
    input  wire logic [POS_W-1:0]         i_position,
    input  wire logic signed [DATA_W-1:0] i_value,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [STAT_W-1:0]             o_status,
    output logic [FIDX_W-1:0]             o_found_index,
    output logic [ECNT_W-1:0]             o_entry_count
);

    t_olie_cmd cmd;

    // The controller sequences capture and execute and owns both handshakes.
    olie_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // The datapath holds the operation, the entry cells, the count and the
    // result register.
    olie_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_kind        (i_kind),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_entry_count (o_entry_count)
    );

endmodule

`default_nettype wire

// ===== design/olie_check.sv =====
`default_nettype none

`include "ordered_list_insert_erase_assert.svh"

module olie_check
    import olie_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_in_valid,
    input wire logic                     o_in_stall,
    input wire logic                     o_out_valid,
    input wire logic                     i_out_stall,
    input wire logic [STAT_W-1:0]        o_status,
    input wire logic [FIDX_W-1:0]        o_found_index,
    input wire logic [ECNT_W-1:0]        o_entry_count
);

    localparam logic [ECNT_W-1:0] FULL_COUNT = ECNT_W'(CAPACITY);

    logic                            in_take;
    logic                            out_hit;
    logic                            out_full;
    logic                            out_hold;
    logic [STAT_W+FIDX_W+ECNT_W-1:0] out_bits;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_hit  = o_out_valid && (o_found_index != '0);
    assign out_full = o_out_valid && (o_status == ST_FULL);
    assign out_hold = o_out_valid && i_out_stall;
    assign out_bits = {o_status, o_found_index, o_entry_count};

    `OLIE_ASSERT_NEXT(a_busy_after_accept, in_take, o_in_stall)
    `OLIE_ASSERT_SAME(a_index_only_on_hit, out_hit, o_status == ST_OK)
    `OLIE_ASSERT_SAME(a_full_means_full, out_full, o_entry_count == FULL_COUNT)
    `OLIE_ASSERT_NEXT(a_result_holds, out_hold, o_out_valid && $stable(out_bits))

endmodule

bind ordered_list_insert_erase olie_check u_check (.*);

`default_nettype wire
